/* hw/rtl/cde_pkg.sv */
package cde_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;

  // Pointer indexes the ring; the count must also hold DEPTH itself.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // Field widths of the request and response.
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 8;
  localparam int RDATA_W = 32;
  localparam int LEN_W   = 8;
  localparam int STAT_W  = 2;

  // Common width for comparing the request count with the element count.
  localparam int CMP_W = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TAKE       = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DROP       = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_STATUS     = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Ring addition; the step never exceeds DEPTH, so one compare and
  // subtract brings the sum back into range.
  function automatic ptr_t ring_add(input ptr_t base, input cnt_t step);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + SUM_W'(step);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* hw/rtl/cde_req_if.sv */
interface cde_req_if;
  logic                         valid;
  logic                         ready;
  logic [cde_pkg::FUNC_W-1:0]   func;
  logic [cde_pkg::VALUE_W-1:0]  value;
  logic [cde_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output func, output value, output count, input ready);
  modport sink   (input valid, input func, input value, input count, output ready);
endinterface

/* hw/rtl/cde_rsp_if.sv */
interface cde_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cde_pkg::RDATA_W-1:0]  read_data;
  logic [cde_pkg::LEN_W-1:0]    length_now;
  logic [cde_pkg::STAT_W-1:0]   status;

  modport source (output valid, output read_data, output length_now, output status,
                  input ready);
  modport sink   (input valid, input read_data, input length_now, input status,
                  output ready);
endinterface

/* hw/rtl/circular_deque_engine_core.sv */
// Ring-buffer deque of cde_pkg::DEPTH elements of cde_pkg::DATA_WIDTH bits.
//
// Requests arrive on req (func, value, count) and each one produces exactly
// one response on rsp (read_data, length_now, status), in order. Both
// channels use a valid/ready handshake; a request moves on a clock edge at
// which valid and ready are both high.
//
// The elements live in a single-port synchronous RAM; the front pointer and
// the element count are registers. Every request except a successful read
// at an offset is finished in the cycle it is accepted, and its response is
// valid in the next cycle, so those requests run at one per cycle while the
// receiver takes each response. A good read goes through the RAM's registered
// read port: the data is registered in the RAM, then in the output register,
// and the block takes no new request while the RAM read is in flight.
//
// The response sits in an output register. A new request is accepted while
// that register is empty or is being emptied in the same cycle; while the
// receiver stalls, the response holds and req.ready stays low.
// Reset (rst, synchronous) empties the deque, points the front at entry
// zero and drops any pending response. The RAM contents are not cleared.
module circular_deque_engine_core (
  input  logic      clk,
  input  logic      rst,
  cde_req_if.sink   req,
  cde_rsp_if.source rsp
);

  // Sequencer states: idle, or waiting for RAM read data.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;

  cde_pkg::ptr_t front;
  cde_pkg::ptr_t front_next;
  cde_pkg::cnt_t elem_count;
  cde_pkg::cnt_t elem_count_next;

  logic                          rsp_valid;
  logic [cde_pkg::RDATA_W-1:0]   rsp_read_data;
  logic [cde_pkg::LEN_W-1:0]     rsp_length;
  logic [cde_pkg::STAT_W-1:0]    rsp_status;

  logic                          accept;
  logic                          read_go;
  logic [cde_pkg::STAT_W-1:0]    status_next;

  logic                          mem_en;
  logic                          mem_we;
  cde_pkg::ptr_t                 mem_addr;
  logic [cde_pkg::DATA_WIDTH-1:0] mem_wdata;
  logic [cde_pkg::DATA_WIDTH-1:0] mem_rdata;

  logic [cde_pkg::CMP_W-1:0]     cmp_req;
  logic [cde_pkg::CMP_W-1:0]     cmp_elem;
  logic                          is_full;
  logic                          deque_empty;
  cde_pkg::cnt_t                 req_step;

  // A request is taken only when no RAM read is in flight and the output
  // register is free, or frees up in this same cycle.
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign cmp_req     = cde_pkg::CMP_W'(req.count);
  assign cmp_elem    = cde_pkg::CMP_W'(elem_count);
  assign is_full     = (elem_count == cde_pkg::CNT_W'(cde_pkg::DEPTH));
  assign deque_empty = (elem_count == '0);
  // Only used where the request count is known to be at most the element
  // count, so the truncation loses nothing.
  assign req_step = cde_pkg::CNT_W'(req.count);

  // Decode one request: new pointer and count, status, and the RAM access.
  // A request touches at most one RAM entry, and a write always lands at
  // the accepting edge, before any later read can be issued, so no
  // forwarding is required.
  always_comb begin
    front_next      = front;
    elem_count_next = elem_count;
    status_next     = cde_pkg::ST_OK;
    read_go         = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = front;
    mem_wdata       = cde_pkg::DATA_WIDTH'(req.value);
    unique case (req.func)
      cde_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          status_next = cde_pkg::ST_FULL;
        end else begin
          front_next      = (front == '0) ? cde_pkg::PTR_W'(cde_pkg::DEPTH - 1)
                                          : front - cde_pkg::PTR_W'(1);
          elem_count_next = elem_count + cde_pkg::CNT_W'(1);
          mem_we          = 1'b1;
          mem_addr        = front_next;
        end
      end
      cde_pkg::FUNC_PUSH_BACK: begin
        if (is_full) begin
          status_next = cde_pkg::ST_FULL;
        end else begin
          elem_count_next = elem_count + cde_pkg::CNT_W'(1);
          mem_we          = 1'b1;
          mem_addr        = cde_pkg::ring_add(front, elem_count);
        end
      end
      cde_pkg::FUNC_POP_FRONT: begin
        if (deque_empty) begin
          status_next = cde_pkg::ST_EMPTY;
        end else begin
          front_next      = (front == cde_pkg::PTR_W'(cde_pkg::DEPTH - 1)) ? '0
                                                : front + cde_pkg::PTR_W'(1);
          elem_count_next = elem_count - cde_pkg::CNT_W'(1);
        end
      end
      cde_pkg::FUNC_READ: begin
        if (cmp_req >= cmp_elem) begin
          status_next = cde_pkg::ST_RANGE;
        end else begin
          read_go  = 1'b1;
          mem_addr = cde_pkg::ring_add(front, req_step);
        end
      end
      cde_pkg::FUNC_TAKE: begin
        if (cmp_req < cmp_elem) begin
          elem_count_next = req_step;
        end
      end
      cde_pkg::FUNC_DROP: begin
        if (cmp_req > cmp_elem) begin
          elem_count_next = '0;
        end else begin
          front_next      = cde_pkg::ring_add(front, req_step);
          elem_count_next = elem_count - req_step;
        end
      end
      default: begin
        // Status request and the unused code change nothing.
      end
    endcase
  end

  assign mem_en = accept && (mem_we || read_go);

  cde_ram #(
    .WIDTH (cde_pkg::DATA_WIDTH),
    .DEPTH (cde_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Deque state and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      elem_count <= '0;
    end else begin
      if (accept) begin
        front      <= front_next;
        elem_count <= elem_count_next;
        if (read_go) begin
          state <= S_READ;
        end
      end else if (state == S_READ) begin
        state <= S_IDLE;
      end
    end
  end

  // Output register. Loading wins over emptying: a load only happens when
  // the register is free or its response is taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_READ) begin
      rsp_valid <= 1'b1;
    end else if (accept && !read_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rsp_read_data <= cde_pkg::RDATA_W'(mem_rdata);
    end else if (accept) begin
      rsp_read_data <= '0;
      rsp_length    <= cde_pkg::LEN_W'(elem_count_next);
      rsp_status    <= status_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_data  = rsp_read_data;
  assign rsp.length_now = rsp_length;
  assign rsp.status     = rsp_status;

endmodule

/* hw/rtl/cde_ram.sv */
module cde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* hw/rtl/cde_chk.sv */
module cde_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [cde_pkg::FUNC_W-1:0]  req_func,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [cde_pkg::RDATA_W-1:0] rsp_read_data,
  input logic [cde_pkg::LEN_W-1:0]   rsp_length_now,
  input logic [cde_pkg::STAT_W-1:0]  rsp_status
);

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
                               $stable(rsp_length_now) && $stable(rsp_status))
    else $error("response changed while stalled");

  // Reset drops any pending response.
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Every request other than a read is answered in the next cycle.
  a_fast_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func != cde_pkg::FUNC_READ |=> rsp_valid)
    else $error("non-read request not answered in one cycle");

  // No request is taken while an unread response blocks the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request accepted while response stalled");

  // A full status only appears with a full deque.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == cde_pkg::ST_FULL |->
      rsp_length_now == cde_pkg::LEN_W'(cde_pkg::DEPTH))
    else $error("full status with a deque that is not full");

endmodule

bind circular_deque_engine_core cde_chk u_cde_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_func       (req.func),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_data  (rsp.read_data),
  .rsp_length_now (rsp.length_now),
  .rsp_status     (rsp.status)
);

/* tb/tb_circular_deque_engine_core.sv */
module tb_circular_deque_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cde_pkg::*;

  // The unused selector value behaves like a status request.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  // Random requests per idling phase, and the run time limit in cycles.
  localparam int PHASE_REQS  = 290;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } deque_req_t;

  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic [LEN_W-1:0]   length_now;
    logic [STAT_W-1:0]  status;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cde_req_if req_ch ();
  cde_rsp_if rsp_ch ();

  circular_deque_engine_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Requests waiting to be driven, and responses the deque owes us, oldest first.
  deque_req_t req_backlog[$];
  deque_rsp_t results_due[$];

  // Idling knobs for the current phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatches = 0;
  int cycle_count = 0;
  int rsps_checked = 0;

  // Shadow copy of the deque: element ring, head index and element count.
  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  int ring_head = 0;
  int ring_len  = 0;

  // Coverage tallies for the closing summary.
  int full_hits  = 0;
  int empty_hits = 0;
  int range_hits = 0;
  int peak_len   = 0;

  // Length the deque will have once every queued request has run; the
  // generator uses it to aim reads, takes and drops at interesting counts.
  int  plan_len = 0;
  bit  filling  = 1'b1;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one accepted request to the shadow deque and return the response
  // it must produce.
  function automatic deque_rsp_t deque_apply(input logic [FUNC_W-1:0] f,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [COUNT_W-1:0] n);
    deque_rsp_t r;
    r = '0;
    r.status = ST_OK;
    case (f)
      FUNC_PUSH_FRONT: begin
        if (ring_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = DATA_WIDTH'(v);
          ring_len++;
        end
      end
      FUNC_PUSH_BACK: begin
        if (ring_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[(ring_head + ring_len) % DEPTH] = DATA_WIDTH'(v);
          ring_len++;
        end
      end
      FUNC_POP_FRONT: begin
        if (ring_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_len--;
        end
      end
      FUNC_READ: begin
        if (int'(n) >= ring_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_data = RDATA_W'(ring_mem[(ring_head + int'(n)) % DEPTH]);
        end
      end
      FUNC_TAKE: begin
        if (int'(n) < ring_len) begin
          ring_len = int'(n);
        end
      end
      FUNC_DROP: begin
        // Dropping more than is held empties the deque but leaves the head alone.
        if (int'(n) > ring_len) begin
          ring_len = 0;
        end else begin
          ring_head = (ring_head + int'(n)) % DEPTH;
          ring_len = ring_len - int'(n);
        end
      end
      default: begin
      end
    endcase
    r.length_now = LEN_W'(ring_len);
    case (r.status)
      ST_FULL:  full_hits++;
      ST_EMPTY: empty_hits++;
      ST_RANGE: range_hits++;
      default: begin
      end
    endcase
    if (ring_len > peak_len) begin
      peak_len = ring_len;
    end
    return r;
  endfunction

  // Queue a request and advance the planned length the same way the deque will.
  task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                           input logic [COUNT_W-1:0] n);
    deque_req_t it;
    it.func  = f;
    it.value = v;
    it.count = n;
    req_backlog.push_back(it);
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (plan_len < DEPTH) plan_len++;
      end
      FUNC_POP_FRONT: begin
        if (plan_len > 0) plan_len--;
      end
      FUNC_TAKE: begin
        if (int'(n) < plan_len) plan_len = int'(n);
      end
      FUNC_DROP: begin
        plan_len = (int'(n) > plan_len) ? 0 : plan_len - int'(n);
      end
      default: begin
      end
    endcase
  endtask

  // Mostly an offset that hits a held element, sometimes one at or past the end.
  function automatic logic [COUNT_W-1:0] pick_offset();
    if (plan_len > 0 && $urandom_range(9) != 0) begin
      return COUNT_W'($urandom_range(plan_len - 1));
    end
    return COUNT_W'($urandom_range(255, plan_len));
  endfunction

  // One random request. The generator alternates between a filling mode,
  // which pushes until the deque is full and keeps pushing a little past
  // that, and a draining mode, which pops and drops until it is empty and
  // then pops a little more. About one request in ten is pure noise.
  task automatic queue_random_req();
    logic [FUNC_W-1:0]  f;
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] n;
    int pick;
    f = FUNC_STATUS;
    n = '0;
    pick = $urandom_range(99);
    v = (pick < 4) ? '0 : (pick < 8) ? '1 : VALUE_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 10) begin
      f = FUNC_W'($urandom_range(7));
      n = COUNT_W'($urandom_range(255));
    end else if (filling) begin
      if (pick < 75) begin
        f = ($urandom_range(1) == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else if (pick < 87) begin
        f = FUNC_READ;
        n = pick_offset();
      end else if (pick < 91) begin
        f = FUNC_POP_FRONT;
      end else if (pick < 96) begin
        f = FUNC_TAKE;
        n = COUNT_W'($urandom_range(255, plan_len));
      end
    end else begin
      if (pick < 40) begin
        f = FUNC_POP_FRONT;
      end else if (pick < 58) begin
        f = FUNC_DROP;
        n = COUNT_W'($urandom_range(6));
      end else if (pick < 65) begin
        f = FUNC_TAKE;
        n = COUNT_W'($urandom_range(plan_len));
      end else if (pick < 80) begin
        f = FUNC_READ;
        n = pick_offset();
      end else if (pick < 90) begin
        f = ($urandom_range(1) == 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else if (pick < 95) begin
        f = FUNC_DROP;
        n = COUNT_W'($urandom_range(255, plan_len));
      end
    end
    queue_req(f, v, n);
    if (filling && plan_len == DEPTH && $urandom_range(5) == 0) begin
      filling = 1'b0;
    end else if (!filling && plan_len == 0 && $urandom_range(3) == 0) begin
      filling = 1'b1;
    end
  endtask

  // Request driver. When the presented request is taken (or nothing is
  // presented), the next one is either launched from the backlog or the
  // channel idles, depending on the idling knob. The shadow
  // deque is advanced at the very edge where the request is accepted, so
  // predictions stay in acceptance order.
  always @(posedge clk) begin : drive_req
    deque_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.func  <= FUNC_STATUS;
      req_ch.value <= '0;
      req_ch.count <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        results_due.push_back(deque_apply(req_ch.func, req_ch.value, req_ch.count));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.func  <= nxt.func;
          req_ch.value <= nxt.value;
          req_ch.count <= nxt.count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response receiver: ready is redrawn every cycle against the stall knob.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response checker: every accepted response is matched field by field
  // against the oldest outstanding prediction.
  always @(posedge clk) begin : check_rsp
    deque_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected response data=%h len=%0d status=%0d",
                                rsp_ch.read_data, rsp_ch.length_now, rsp_ch.status));
      end else begin
        want = results_due.pop_front();
        rsps_checked++;
        if (rsp_ch.read_data !== want.read_data) begin
          flag_mismatch($sformatf("read_data got %h, want %h",
                                  rsp_ch.read_data, want.read_data));
        end
        if (rsp_ch.length_now !== want.length_now) begin
          flag_mismatch($sformatf("length_now got %0d, want %0d",
                                  rsp_ch.length_now, want.length_now));
        end
        if (rsp_ch.status !== want.status) begin
          flag_mismatch($sformatf("status got %0d, want %0d",
                                  rsp_ch.status, want.status));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph;
    int i;
    // Every input is known from time zero, before the first clock edge.
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_STATUS;
    req_ch.value = '0;
    req_ch.count = '0;
    rsp_ch.ready = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Four idling phases: none, sender gaps, receiver stalls, then both.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 49; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 49; end
        default: begin send_idle_pct <= 29; recv_stall_pct <= 29; end
      endcase

      if (ph == 0) begin
        // Corner cases on the empty deque: status, pop, read, take and
        // drops of zero and of more than is held.
        queue_req(FUNC_STATUS, '0, '0);
        queue_req(FUNC_POP_FRONT, '0, '0);
        queue_req(FUNC_READ, '0, '0);
        queue_req(FUNC_TAKE, '0, '0);
        queue_req(FUNC_DROP, '0, '0);
        queue_req(FUNC_DROP, '0, '1);
        // Pushes at both ends with extreme data, wrapping the head below zero.
        queue_req(FUNC_PUSH_BACK, '0, '0);
        queue_req(FUNC_PUSH_FRONT, '1, '1);
        queue_req(FUNC_PUSH_BACK, 32'hA5A5_A5A5, '0);
        queue_req(FUNC_PUSH_FRONT, 32'h5A5A_5A5A, '0);
        // Reads at the head, at the tail, one past the end and at the top offset.
        queue_req(FUNC_READ, '0, 8'd0);
        queue_req(FUNC_READ, '0, 8'd3);
        queue_req(FUNC_READ, '0, 8'd4);
        queue_req(FUNC_READ, '0, '1);
        queue_req(FUNC_UNUSED, '1, '1);
        // Take longer than the length changes nothing; a shorter one truncates.
        queue_req(FUNC_TAKE, '0, 8'd200);
        queue_req(FUNC_TAKE, '0, 8'd3);
        queue_req(FUNC_DROP, '0, 8'd1);
        queue_req(FUNC_POP_FRONT, '0, '0);
        // Over-long drop empties the deque with the head left in place.
        queue_req(FUNC_DROP, '0, 8'd9);
        queue_req(FUNC_PUSH_FRONT, 32'h1234_5678, '0);
        queue_req(FUNC_READ, '0, 8'd0);
        // Drop of exactly the length, then a pop on the emptied deque.
        queue_req(FUNC_DROP, '0, 8'd1);
        queue_req(FUNC_POP_FRONT, '0, '0);
      end

      for (i = 0; i < PHASE_REQS; i++) begin
        queue_random_req();
      end

      // Let the phase drain completely before the idling pattern changes.
      while (req_backlog.size() != 0 || req_ch.valid || results_due.size() != 0) begin
        @(posedge clk);
      end
    end

    // An extra settling wait, so that any stray response would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      flag_mismatch($sformatf("%0d responses never arrived", results_due.size()));
    end

    $display("checked %0d responses over four idling phases, peak length %0d of %0d",
             rsps_checked, peak_len, DEPTH);
    $display("error responses seen: %0d full, %0d empty, %0d out of range; %0d mismatches",
             full_hits, empty_hits, range_hits, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
